[rtl/scsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package scsa_pkg;

  localparam int ADDR_W      = 48;
  localparam int SIZE_W      = 16;
  localparam int CLS_W       = 4;
  localparam int STAT_W      = 3;
  localparam int CB_W        = 12;
  localparam int MAX_CLASSES = 12;

  localparam logic [CB_W-1:0] CLASS_BYTES [MAX_CLASSES] = '{
    12'd8, 12'd16, 12'd32, 12'd48, 12'd80, 12'd128,
    12'd192, 12'd288, 12'd448, 12'd672, 12'd1024, 12'd2048
  };

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK           = 3'd0,
    STAT_TOO_LARGE    = 3'd1,
    STAT_EXHAUSTED    = 3'd2,
    STAT_IGNORED      = 3'd3,
    STAT_PAGE_ALIGNED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_A_CLASS,
    S_A_HEAD,
    S_A_POP,
    S_A_ADDR,
    S_F_OFF,
    S_F_REGION,
    S_F_ROFF,
    S_F_MUL,
    S_F_PUSH,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_SWEEP,
    STEP_ACCEPT,
    STEP_A_CLASS,
    STEP_A_HEAD,
    STEP_A_POP,
    STEP_A_ADDR,
    STEP_F_OFF,
    STEP_F_REGION,
    STEP_F_ROFF,
    STEP_F_MUL,
    STEP_F_PUSH
  } dp_step_t;

  typedef struct packed {
    dp_step_t step;
    logic     load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

[rtl/scsa_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface scsa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [scsa_pkg::SIZE_W-1:0]   req_size;
  logic [scsa_pkg::ADDR_W-1:0]   free_addr;

  modport source (output valid, cmd, req_size, free_addr, input ready);
  modport sink   (input valid, cmd, req_size, free_addr, output ready);
endinterface

interface scsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [scsa_pkg::ADDR_W-1:0]   block_addr;
  logic [scsa_pkg::CLS_W-1:0]    size_class;
  logic [scsa_pkg::STAT_W-1:0]   status;

  modport source (output valid, block_addr, size_class, status, input ready);
  modport sink   (input valid, block_addr, size_class, status, output ready);
endinterface

interface scsa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [scsa_pkg::ADDR_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/scsa_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module scsa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_cmd,
  input  wire scsa_pkg::dp_sts_t  sts,
  output scsa_pkg::ctl_cmd_t      cmd,
  output logic                    in_ready
);

  scsa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scsa_pkg::S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.step     = scsa_pkg::STEP_NONE;
    cmd.load_out = 1'b0;
    in_ready     = 1'b0;
    unique case (state_r)
      scsa_pkg::S_SWEEP: begin
        cmd.step = scsa_pkg::STEP_SWEEP;
        if (sts.sweep_done) state_nxt = scsa_pkg::S_IDLE;
      end
      scsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step  = scsa_pkg::STEP_ACCEPT;
          state_nxt = (in_cmd == scsa_pkg::CMD_FREE) ? scsa_pkg::S_F_OFF
                                                     : scsa_pkg::S_A_CLASS;
        end
      end
      scsa_pkg::S_A_CLASS: begin
        cmd.step  = scsa_pkg::STEP_A_CLASS;
        state_nxt = scsa_pkg::S_A_HEAD;
      end
      scsa_pkg::S_A_HEAD: begin
        cmd.step  = scsa_pkg::STEP_A_HEAD;
        state_nxt = scsa_pkg::S_A_POP;
      end
      scsa_pkg::S_A_POP: begin
        cmd.step  = scsa_pkg::STEP_A_POP;
        state_nxt = scsa_pkg::S_A_ADDR;
      end
      scsa_pkg::S_A_ADDR: begin
        cmd.step  = scsa_pkg::STEP_A_ADDR;
        state_nxt = scsa_pkg::S_OUT;
      end
      scsa_pkg::S_F_OFF: begin
        cmd.step  = scsa_pkg::STEP_F_OFF;
        state_nxt = scsa_pkg::S_F_REGION;
      end
      scsa_pkg::S_F_REGION: begin
        cmd.step  = scsa_pkg::STEP_F_REGION;
        state_nxt = scsa_pkg::S_F_ROFF;
      end
      scsa_pkg::S_F_ROFF: begin
        cmd.step  = scsa_pkg::STEP_F_ROFF;
        state_nxt = scsa_pkg::S_F_MUL;
      end
      scsa_pkg::S_F_MUL: begin
        cmd.step  = scsa_pkg::STEP_F_MUL;
        state_nxt = scsa_pkg::S_F_PUSH;
      end
      scsa_pkg::S_F_PUSH: begin
        cmd.step  = scsa_pkg::STEP_F_PUSH;
        state_nxt = scsa_pkg::S_OUT;
      end
      scsa_pkg::S_OUT: begin
        cmd.load_out = sts.out_free;
        if (sts.out_free) state_nxt = scsa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = scsa_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/scsa_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module scsa_dp #(
  parameter int NUM_CLASSES     = 12,
  parameter int SLOTS_PER_CLASS = 1024,
  parameter int REGION_PAGES    = 2,
  parameter int PAGE_BYTES      = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire scsa_pkg::ctl_cmd_t            cmd,
  output scsa_pkg::dp_sts_t                  sts,
  input  wire logic                          cfg_we,
  input  wire logic [scsa_pkg::ADDR_W-1:0]   cfg_data,
  input  wire logic [scsa_pkg::SIZE_W-1:0]   in_size,
  input  wire logic [scsa_pkg::ADDR_W-1:0]   in_addr,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [scsa_pkg::ADDR_W-1:0]        out_block_addr,
  output logic [scsa_pkg::CLS_W-1:0]         out_size_class,
  output logic [scsa_pkg::STAT_W-1:0]        out_status
);

  localparam int AW     = scsa_pkg::ADDR_W;
  localparam int ACT    = (NUM_CLASSES < scsa_pkg::MAX_CLASSES) ? NUM_CLASSES
                                                                : scsa_pkg::MAX_CLASSES;
  localparam int REGION = REGION_PAGES * PAGE_BYTES;
  localparam int RBW    = $clog2(REGION);
  localparam int SLW    = $clog2(SLOTS_PER_CLASS + 1);
  localparam int SIW    = $clog2(SLOTS_PER_CLASS);
  localparam int CIW    = (ACT > 1) ? $clog2(ACT) : 1;
  localparam int PGW    = $clog2(PAGE_BYTES);
  localparam int K      = RBW + 12;
  localparam int MW     = RBW + 10;
  localparam int PW     = RBW + MW;
  localparam int QW     = PW - K;
  localparam int MPW    = SLW + 1 + scsa_pkg::CB_W;
  localparam int LDEPTH = ACT * (2 ** SIW);
  localparam int LAW    = $clog2(LDEPTH);
  localparam logic [63:0] SPAN64 = 64'(ACT) * 64'(REGION);
  localparam logic [AW-1:0] POOL_SPAN = SPAN64[AW-1:0];
  localparam logic [SLW-1:0] NO_SLOT = SLW'(SLOTS_PER_CLASS);

  // per-class constants
  logic [scsa_pkg::CB_W-1:0] cls_bytes  [ACT];
  logic [SLW-1:0]            slot_cnt   [ACT];
  logic [MW-1:0]             recip      [ACT];
  logic [AW-1:0]             region_off [ACT];

  for (genvar g = 0; g < ACT; g++) begin : g_cls
    localparam logic [63:0] CB = 64'(scsa_pkg::CLASS_BYTES[g]);
    localparam logic [63:0] NS = 64'(REGION) / CB - 64'd1;
    localparam logic [63:0] SC = (NS < 64'(SLOTS_PER_CLASS)) ? NS : 64'(SLOTS_PER_CLASS);
    localparam logic [63:0] RC = ((64'd1 << K) + CB - 64'd1) / CB;
    localparam logic [63:0] RO = 64'(g) * 64'(REGION);
    assign cls_bytes[g]  = CB[scsa_pkg::CB_W-1:0];
    assign slot_cnt[g]   = SC[SLW-1:0];
    assign recip[g]      = RC[MW-1:0];
    assign region_off[g] = RO[AW-1:0];
  end

  logic [AW-1:0]              pool_base_r;
  logic [SLW-1:0]             head_r [ACT];
  logic [CIW-1:0]             swc_r;
  logic [SIW-1:0]             sws_r;
  logic                       out_valid_r;

  logic [scsa_pkg::SIZE_W-1:0] size_r;
  logic [AW-1:0]              addr_r;
  logic [CIW-1:0]             cls_r;
  logic                       too_large_r, exh_r, null_r, page_r, outpool_r;
  logic [SLW-1:0]             s_r;
  logic [SLW-1:0]             link_rd_r;
  logic [AW-1:0]              base_r, amul_r, off_r;
  logic [RBW-1:0]             roff_r;
  logic [PW-1:0]              prod_r;
  logic [AW-1:0]              res_addr_r;
  logic [CIW-1:0]             res_cls_r;
  scsa_pkg::status_t          res_st_r;
  logic [AW-1:0]              out_addr_r;
  logic [scsa_pkg::CLS_W-1:0] out_cls_r;
  scsa_pkg::status_t          out_st_r;

  logic [SLW-1:0] link_mem [LDEPTH];

  // class pick and region pick
  logic [CIW-1:0] csel, rsel;
  logic           cfound;

  always_comb begin
    csel   = '0;
    cfound = 1'b0;
    for (int c = ACT - 1; c >= 0; c--) begin
      if (scsa_pkg::SIZE_W'(cls_bytes[c]) >= size_r) begin
        csel   = CIW'(c);
        cfound = 1'b1;
      end
    end
  end

  always_comb begin
    rsel = '0;
    for (int k = 1; k < ACT; k++) begin
      if (off_r >= region_off[k]) rsel = CIW'(k);
    end
  end

  logic [SLW-1:0] head_sel;
  logic [LAW-1:0] rd_idx, push_idx, swp_idx;
  logic [SLW:0]   s_inc;
  logic [MPW-1:0] amul_prod;
  logic [AW-1:0]  amul_full;
  logic [AW-1:0]  roff_full;
  logic [PW-1:0]  prod_full;
  logic [QW-1:0]  q;
  logic           q_ok, push_ok;
  logic [SLW-1:0] s_push;
  logic [SLW-1:0] swp_val;
  logic           sweep_done;
  logic           out_free;

  assign head_sel  = head_r[cls_r];
  assign rd_idx    = LAW'({cls_r, head_sel[SIW-1:0]});
  assign s_inc     = {1'b0, s_r} + (SLW+1)'(1);
  assign amul_prod = MPW'(s_inc) * MPW'(cls_bytes[cls_r]);
  assign amul_full = AW'(amul_prod);
  assign roff_full = off_r - region_off[cls_r];
  assign prod_full = PW'(roff_r) * PW'(recip[cls_r]);
  assign q         = prod_r[PW-1:K];
  assign q_ok      = (q != '0) && ((32'(q) - 32'd1) < 32'(slot_cnt[cls_r]));
  assign s_push    = SLW'(32'(q) - 32'd1);
  assign push_ok   = !null_r && !page_r && !outpool_r && q_ok;
  assign push_idx  = LAW'({cls_r, s_push[SIW-1:0]});
  assign swp_idx   = LAW'({swc_r, sws_r});
  assign swp_val   = ((32'(sws_r) + 32'd1) < 32'(slot_cnt[swc_r])) ? SLW'(32'(sws_r) + 32'd1)
                                                                   : NO_SLOT;
  assign sweep_done = (swc_r == CIW'(ACT - 1)) && (sws_r == '1);
  assign out_free   = !out_valid_r || out_ready;

  assign sts.sweep_done = sweep_done;
  assign sts.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
      swc_r       <= '0;
      sws_r       <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < ACT; c++) head_r[c] <= '0;
    end else begin
      if (cfg_we) pool_base_r <= cfg_data;
      if (cmd.step == scsa_pkg::STEP_SWEEP) begin
        if (sws_r == '1) begin
          sws_r <= '0;
          swc_r <= swc_r + CIW'(1);
        end else begin
          sws_r <= sws_r + SIW'(1);
        end
      end
      if (cmd.step == scsa_pkg::STEP_A_POP && !too_large_r && !exh_r)
        head_r[cls_r] <= link_rd_r;
      if (cmd.step == scsa_pkg::STEP_F_PUSH && push_ok)
        head_r[cls_r] <= s_push;
      if (cmd.load_out)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == scsa_pkg::STEP_SWEEP)
      link_mem[swp_idx] <= swp_val;
    else if (cmd.step == scsa_pkg::STEP_F_PUSH && push_ok)
      link_mem[push_idx] <= head_sel;
    if (cmd.step == scsa_pkg::STEP_A_HEAD)
      link_rd_r <= link_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.step)
      scsa_pkg::STEP_ACCEPT: begin
        size_r <= in_size;
        addr_r <= in_addr;
      end
      scsa_pkg::STEP_A_CLASS: begin
        cls_r       <= csel;
        too_large_r <= !cfound;
      end
      scsa_pkg::STEP_A_HEAD: begin
        s_r   <= head_sel;
        exh_r <= head_sel >= slot_cnt[cls_r];
      end
      scsa_pkg::STEP_A_POP: begin
        amul_r <= amul_full;
        base_r <= pool_base_r + region_off[cls_r];
      end
      scsa_pkg::STEP_A_ADDR: begin
        if (too_large_r) begin
          res_addr_r <= '0;
          res_cls_r  <= '0;
          res_st_r   <= scsa_pkg::STAT_TOO_LARGE;
        end else if (exh_r) begin
          res_addr_r <= '0;
          res_cls_r  <= cls_r;
          res_st_r   <= scsa_pkg::STAT_EXHAUSTED;
        end else begin
          res_addr_r <= base_r + amul_r;
          res_cls_r  <= cls_r;
          res_st_r   <= scsa_pkg::STAT_OK;
        end
      end
      scsa_pkg::STEP_F_OFF: begin
        null_r <= addr_r == '0;
        page_r <= addr_r[PGW-1:0] == '0;
        off_r  <= addr_r - pool_base_r;
      end
      scsa_pkg::STEP_F_REGION: begin
        cls_r     <= rsel;
        outpool_r <= off_r >= POOL_SPAN;
      end
      scsa_pkg::STEP_F_ROFF: begin
        roff_r <= roff_full[RBW-1:0];
      end
      scsa_pkg::STEP_F_MUL: begin
        prod_r <= prod_full;
      end
      scsa_pkg::STEP_F_PUSH: begin
        res_addr_r <= '0;
        if (null_r) begin
          res_cls_r <= '0;
          res_st_r  <= scsa_pkg::STAT_IGNORED;
        end else if (page_r) begin
          res_cls_r <= '0;
          res_st_r  <= scsa_pkg::STAT_PAGE_ALIGNED;
        end else if (!push_ok) begin
          res_cls_r <= '0;
          res_st_r  <= scsa_pkg::STAT_IGNORED;
        end else begin
          res_cls_r <= cls_r;
          res_st_r  <= scsa_pkg::STAT_OK;
        end
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      out_addr_r <= res_addr_r;
      out_cls_r  <= scsa_pkg::CLS_W'(res_cls_r);
      out_st_r   <= res_st_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_block_addr = out_addr_r;
  assign out_size_class = out_cls_r;
  assign out_status     = out_st_r;

endmodule
`default_nettype wire

[rtl/size_class_slab_allocator_core.sv]
// An allocate steps through A_CLASS, A_HEAD, A_POP and A_ADDR, a free through F_OFF,
// F_REGION, F_ROFF, F_MUL and F_PUSH, before OUT loads the registered result. One request
// is handled at a time: in_ready is high only in IDLE; OUT waits for a free output.
// Reset: synchronous active-low; afterwards the link store is swept one entry per cycle,
// min(NUM_CLASSES,12) * 2**clog2(SLOTS_PER_CLASS) entries (12288 by default), before
// the first request is taken; config writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
module size_class_slab_allocator_core #(
  parameter int NUM_CLASSES     = 12,
  parameter int SLOTS_PER_CLASS = 1024,
  parameter int REGION_PAGES    = 2,
  parameter int PAGE_BYTES      = 4096
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  scsa_req_if.sink   in_req,
  scsa_rsp_if.source out_rsp,
  scsa_cfg_if.sink   cfg_wr
);

  scsa_pkg::ctl_cmd_t cmd;
  scsa_pkg::dp_sts_t  sts;
  logic               in_ready;

  assign in_req.ready = in_ready;
  assign cfg_wr.ready = 1'b1;

  scsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_cmd   (in_req.cmd),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  scsa_dp #(
    .NUM_CLASSES     (NUM_CLASSES),
    .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
    .REGION_PAGES    (REGION_PAGES),
    .PAGE_BYTES      (PAGE_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_wr.valid),
    .cfg_data       (cfg_wr.data),
    .in_size        (in_req.req_size),
    .in_addr        (in_req.free_addr),
    .out_ready      (out_rsp.ready),
    .out_valid      (out_rsp.valid),
    .out_block_addr (out_rsp.block_addr),
    .out_size_class (out_rsp.size_class),
    .out_status     (out_rsp.status)
  );

endmodule
`default_nettype wire
